// File: hdl/assert_macros.svh
// Assertion macros shared by the list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/ple_pkg.sv
// Types and constants for the positional list engine.
package ple_pkg;

  localparam int OP_W    = 3;
  localparam int IDX_W   = 5;
  localparam int VAL_W   = 31;
  localparam int RES_W   = 32;
  localparam int ENTRY_W = 5;

  localparam logic [OP_W-1:0] OP_GET    = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic signed [RES_W-1:0] RES_FAIL = {RES_W{1'b1}};
  localparam logic signed [RES_W-1:0] RES_ONE  = RES_W'(1);
  localparam logic signed [RES_W-1:0] RES_ZERO = '0;

  // Cell update modes
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_ROTATE = 2'd1;
  localparam logic [1:0] CELL_INSERT = 2'd2;
  localparam logic [1:0] CELL_REMOVE = 2'd3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

// File: hdl/ple_cell.sv
// One entry: holds a value; loads the insert value or a neighbor's on shifts.
module ple_cell #(
  parameter int POS_W = 4
) (
  input  logic                    clk,
  input  ple_pkg::cell_ctl_t      ctl,
  input  logic [POS_W-1:0]        pos,
  input  logic [ple_pkg::VAL_W-1:0] lower,
  input  logic [ple_pkg::VAL_W-1:0] upper,
  output logic [ple_pkg::VAL_W-1:0] data
);
  import ple_pkg::*;

  localparam int CW = (POS_W > IDX_W) ? POS_W : IDX_W;

  logic [CW-1:0]    pos_ext;
  logic [CW-1:0]    idx_ext;
  logic [VAL_W-1:0] data_next;

  assign pos_ext = CW'(pos);
  assign idx_ext = CW'(ctl.idx);

  always_comb begin
    data_next = data;
    case (ctl.mode)
      CELL_ROTATE: begin
        data_next = upper;
      end
      CELL_INSERT: begin
        if (pos_ext > idx_ext) begin
          data_next = lower;
        end else if (pos_ext == idx_ext) begin
          data_next = ctl.value;
        end
      end
      CELL_REMOVE: begin
        if (pos_ext >= idx_ext) begin
          data_next = upper;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// File: hdl/positional_list_engine_top.sv
// Positional list engine top level: a row of entry cells plus its sequencer.
// Insert, clear, unused codes and out-of-range get/remove: result registered in the cycle after the beat.
// Get and find: one full rotation of the cell ring past cell 0.
// Remove: the rotation and then the shift-down state.
// One item at a time; the next beat is taken once the engine is idle and the result register is free.
// Synchronous active-high reset empties the list; entry contents are not cleared.
`include "assert_macros.svh"

module positional_list_engine_top #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [ple_pkg::OP_W-1:0]      operation,
  input  logic [ple_pkg::IDX_W-1:0]     index,
  input  logic [ple_pkg::VAL_W-1:0]     value,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic signed [ple_pkg::RES_W-1:0] result,
  output logic                          success,
  output logic [ple_pkg::ENTRY_W-1:0]   entry_count
);
  import ple_pkg::*;

  localparam int PW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;

  logic [1:0]       state, state_next;
  logic [PW-1:0]    step, step_next;
  logic [CNT_W-1:0] count, count_next;
  logic [OP_W-1:0]  cur_op, cur_op_next;
  logic [IDX_W-1:0] cur_idx, cur_idx_next;
  logic [VAL_W-1:0] key, key_next;
  logic signed [RES_W-1:0] res, res_next;
  logic             found, found_next;

  logic             req_accept;
  logic             ins_ok;
  logic             idx_in_range;
  logic             load_out;
  logic signed [RES_W-1:0] out_res;
  logic             out_ok;
  logic             scan_hit;
  logic             scan_last;
  logic signed [RES_W-1:0] res_scan;
  logic             found_scan;

  cell_ctl_t        cell_ctl;
  logic [VAL_W-1:0] cell_data [DEPTH];

  // Cell ring: lower neighbor for insert, upper neighbor (wrapping) for remove/rotate.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [VAL_W-1:0] lower_data;
    if (k == 0) begin : g_first
      assign lower_data = '0;
    end else begin : g_rest
      assign lower_data = cell_data[k-1];
    end
    ple_cell #(.POS_W(PW)) u_cell (
      .clk   (clk),
      .ctl   (cell_ctl),
      .pos   (PW'(k)),
      .lower (lower_data),
      .upper (cell_data[(k + 1) % DEPTH]),
      .data  (cell_data[k])
    );
  end

  assign req_stall  = rst || (state != ST_IDLE) || (rsp_valid && rsp_stall);
  assign req_accept = req_valid && !req_stall;

  assign idx_in_range = CMP_W'(index) < CMP_W'(count);
  assign ins_ok = (CMP_W'(index) <= CMP_W'(count)) && (count < CNT_W'(DEPTH));

  // Cell 0 shows entry[step] during the scan.
  assign scan_last = step == PW'(DEPTH - 1);
  always_comb begin
    if (cur_op == OP_FIND) begin
      scan_hit = !found && (CMP_W'(step) < CMP_W'(count)) && (cell_data[0] == key);
    end else begin
      scan_hit = CMP_W'(step) == CMP_W'(cur_idx);
    end
    res_scan   = res;
    found_scan = found | scan_hit;
    if (scan_hit) begin
      if (cur_op == OP_FIND) begin
        res_scan = RES_W'(step);
      end else begin
        res_scan = RES_W'(cell_data[0]);
      end
    end
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    count_next   = count;
    cur_op_next  = cur_op;
    cur_idx_next = cur_idx;
    key_next     = key;
    res_next     = res;
    found_next   = found;
    load_out     = 1'b0;
    out_res      = RES_FAIL;
    out_ok       = 1'b0;
    cell_ctl.mode  = CELL_HOLD;
    cell_ctl.idx   = index;
    cell_ctl.value = value;

    case (state)
      ST_IDLE: begin
        if (req_accept) begin
          cur_op_next  = operation;
          cur_idx_next = index;
          key_next     = value;
          res_next     = RES_FAIL;
          found_next   = 1'b0;
          step_next    = '0;
          case (operation)
            OP_GET, OP_REMOVE: begin
              if (idx_in_range) begin
                state_next = ST_SCAN;
              end else begin
                load_out = 1'b1;
              end
            end
            OP_FIND: begin
              state_next = ST_SCAN;
            end
            OP_INSERT: begin
              load_out = 1'b1;
              if (ins_ok) begin
                cell_ctl.mode = CELL_INSERT;
                count_next    = count + CNT_W'(1);
                out_res       = RES_ONE;
                out_ok        = 1'b1;
              end
            end
            OP_CLEAR: begin
              load_out   = 1'b1;
              count_next = '0;
              out_res    = RES_ZERO;
              out_ok     = 1'b1;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cell_ctl.mode = CELL_ROTATE;
        res_next      = res_scan;
        found_next    = found_scan;
        step_next     = step + PW'(1);
        if (scan_last) begin
          step_next = '0;
          if (cur_op == OP_REMOVE) begin
            state_next = ST_SHIFT;
          end else begin
            state_next = ST_IDLE;
            load_out   = 1'b1;
            out_res    = res_scan;
            out_ok     = found_scan;
          end
        end
      end
      ST_SHIFT: begin
        cell_ctl.mode = CELL_REMOVE;
        cell_ctl.idx  = cur_idx;
        count_next    = count - CNT_W'(1);
        state_next    = ST_IDLE;
        load_out      = 1'b1;
        out_res       = res;
        out_ok        = 1'b1;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      step      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      step      <= step_next;
      rsp_valid <= load_out | (rsp_valid & rsp_stall);
    end
  end

  always_ff @(posedge clk) begin
    cur_op  <= cur_op_next;
    cur_idx <= cur_idx_next;
    key     <= key_next;
    res     <= res_next;
    found   <= found_next;
    if (load_out) begin
      result      <= out_res;
      success     <= out_ok;
      entry_count <= ENTRY_W'(count_next);
    end
  end

  `ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `ASSERT_NEXT(a_insert_grows, clk, rst, req_accept && operation == OP_INSERT && ins_ok,
               count == $past(count) + CNT_W'(1))
  `ASSERT_NEXT(a_scan_done, clk, rst, state == ST_SCAN && scan_last && cur_op != OP_REMOVE,
               rsp_valid && state == ST_IDLE)
  `ASSERT_IMPLIES(a_fail_code, clk, rst, rsp_valid && !success, result == RES_FAIL)

endmodule

// File: verif/positional_list_engine_top_test.sv
// Self-checking testbench for the positional list engine: random and directed list ops.
`timescale 1ns / 100ps

module positional_list_engine_top_test;
  import ple_pkg::*;

  localparam int DEPTH          = 16;
  localparam int RANDOM_ITEMS   = 700;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int LONG_HOLD      = 300;
  localparam int OP_CODE_MAX    = (1 << OP_W) - 1;
  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_pattern_e;

  typedef struct {
    logic signed [RES_W-1:0] result;
    logic                    success;
    logic [ENTRY_W-1:0]      entry_count;
  } list_reply_t;

  class list_scoreboard;
    logic [VAL_W-1:0] slots[DEPTH];
    int               held;
    int               failures;
    list_reply_t      expected_replies[$];

    function new();
      held     = 0;
      failures = 0;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    // Apply one accepted request to the shadow list and queue its reply.
    function void note_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                               logic [VAL_W-1:0] val);
      list_reply_t rep;
      int          pos;
      pos         = int'(idx);
      rep.result  = RES_FAIL;
      rep.success = 1'b0;
      case (op)
        OP_GET: begin
          if (pos < held) begin
            rep.result  = RES_W'(slots[pos]);
            rep.success = 1'b1;
          end
        end
        OP_INSERT: begin
          if (pos <= held && held < DEPTH) begin
            for (int k = held; k > pos; k--) slots[k] = slots[k-1];
            slots[pos]  = val;
            held++;
            rep.result  = RES_ONE;
            rep.success = 1'b1;
          end
        end
        OP_FIND: begin
          for (int k = 0; k < held; k++) begin
            if (!rep.success && slots[k] == val) begin
              rep.result  = RES_W'(k);
              rep.success = 1'b1;
            end
          end
        end
        OP_REMOVE: begin
          if (pos < held) begin
            rep.result = RES_W'(slots[pos]);
            for (int k = pos; k + 1 < held; k++) slots[k] = slots[k+1];
            held--;
            rep.success = 1'b1;
          end
        end
        OP_CLEAR: begin
          held        = 0;
          rep.result  = RES_ZERO;
          rep.success = 1'b1;
        end
        default: ;
      endcase
      rep.entry_count = ENTRY_W'(held);
      expected_replies.push_back(rep);
    endfunction

    function void check_response(logic signed [RES_W-1:0] res, logic ok,
                                 logic [ENTRY_W-1:0] cnt);
      list_reply_t exp_rep;
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected reply: result %0d success %0d entry_count %0d",
                 $time, res, ok, cnt);
        failures++;
        return;
      end
      exp_rep = expected_replies.pop_front();
      if (res !== exp_rep.result) begin
        $display("%0t: result mismatch: expected %0d, actual %0d",
                 $time, exp_rep.result, res);
        failures++;
      end
      if (ok !== exp_rep.success) begin
        $display("%0t: success mismatch: expected %0d, actual %0d",
                 $time, exp_rep.success, ok);
        failures++;
      end
      if (cnt !== exp_rep.entry_count) begin
        $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                 $time, exp_rep.entry_count, cnt);
        failures++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    req_valid = 1'b0;
  logic                    req_stall;
  logic [OP_W-1:0]         operation = OP_GET;
  logic [IDX_W-1:0]        index = '0;
  logic [VAL_W-1:0]        value = '0;
  logic                    rsp_valid;
  logic                    rsp_stall = 1'b0;
  logic signed [RES_W-1:0] result;
  logic                    success;
  logic [ENTRY_W-1:0]      entry_count;

  list_scoreboard sb;

  positional_list_engine_top #(.DEPTH(DEPTH)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .operation   (operation),
    .index       (index),
    .value       (value),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .result      (result),
    .success     (success),
    .entry_count (entry_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one request beat; returns at the edge where it is taken.
  task automatic send_beat(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                           logic [VAL_W-1:0] val);
    req_valid <= 1'b1;
    operation <= op;
    index     <= idx;
    value     <= val;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    sb.note_request(op, idx, val);
  endtask

  // bias 0 grows the list, 1 shrinks it, 2 mixes.
  task automatic random_beat(int bias);
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    int               pick;
    int               ins_w;
    int               rem_w;
    int               vsel;
    ins_w = (bias == 0) ? 60 : (bias == 1) ? 15 : 30;
    rem_w = (bias == 1) ? 45 : (bias == 0) ? 10 : 25;
    pick  = $urandom_range(0, 99);
    if (pick < ins_w)                        op = OP_INSERT;
    else if (pick < ins_w + rem_w)           op = OP_REMOVE;
    else if (pick < ins_w + rem_w + 2)       op = OP_CLEAR;
    else if (pick < ins_w + rem_w + 4)       op = OP_W'(OP_CODE_MAX - $urandom_range(0, 2));
    else if (pick < ins_w + rem_w + 4 + (96 - ins_w - rem_w) / 2) op = OP_GET;
    else                                     op = OP_FIND;

    if ($urandom_range(0, 9) == 0) idx = IDX_W'($urandom_range(0, 31));
    else                           idx = IDX_W'($urandom_range(0, sb.held));

    vsel = $urandom_range(0, 9);
    if (vsel < 5)                      val = VAL_W'($urandom_range(0, 7));
    else if (vsel < 7 && sb.held > 0)  val = sb.slots[$urandom_range(0, sb.held - 1)];
    else if (vsel < 9)                 val = VAL_W'($urandom);
    else                               val = $urandom_range(0, 1) ? VAL_MAX : '0;
    send_beat(op, idx, val);
  endtask

  initial begin : stimulus
    int sent;
    int burst;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty list first: every positional op fails; then directed inserts, gets, finds, removes and clears
    send_beat(OP_GET, 5'd0, 31'd0);
    send_beat(OP_REMOVE, 5'd0, 31'd0);
    send_beat(OP_FIND, 5'd0, 31'd0);
    send_beat(OP_INSERT, 5'd1, 31'd5);
    send_beat(OP_INSERT, 5'd0, VAL_MAX);
    send_beat(OP_INSERT, 5'd0, 31'd0);
    send_beat(OP_INSERT, 5'd2, 31'h2AAA_AAAA);
    send_beat(OP_INSERT, 5'd1, 31'h5555_5555);
    send_beat(OP_GET, 5'd3, 31'd0);
    send_beat(OP_GET, 5'd0, 31'd0);
    send_beat(OP_GET, 5'd4, 31'd0);
    send_beat(OP_GET, 5'd31, 31'd0);
    send_beat(OP_FIND, 5'd16, VAL_MAX);
    send_beat(OP_FIND, 5'd0, 31'h1234);
    send_beat(OP_REMOVE, 5'd1, 31'd0);
    send_beat(OP_REMOVE, 5'd31, 31'd0);
    send_beat(OP_REMOVE, 5'd2, 31'd0);
    for (int c = OP_CLEAR + 1; c <= OP_CODE_MAX; c++) send_beat(OP_W'(c), 5'd0, VAL_MAX);
    send_beat(OP_CLEAR, 5'd0, 31'd0);
    send_beat(OP_GET, 5'd0, 31'd0);
    send_beat(OP_INSERT, 5'd0, 31'h1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst; i++) begin
        random_beat((sent / 50) % 3);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    req_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin : receiver
    rx_pattern_e pattern = RX_OPEN;
    int          pattern_left = 0;
    int          hold_left = 0;
    int          replies = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        sb.check_response(result, success, entry_count);
        replies++;
        // long hold-off so the engine backs up into its request side
        if (replies == 120 || replies == 450) hold_left = LONG_HOLD;
      end
      if (pattern_left == 0) begin
        pattern      = rx_pattern_e'($urandom_range(0, 3));
        pattern_left = $urandom_range(10, 80);
      end
      pattern_left--;
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        case (pattern)
          RX_OPEN:  rsp_stall <= 1'b0;
          RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
          default:  rsp_stall <= !rsp_stall;
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/ple_pkg.sv
hdl/ple_cell.sv
hdl/positional_list_engine_top.sv
verif/positional_list_engine_top_test.sv
